### src/sec_pkg.sv
// Shared types and constants for the strip energy calibration block.
`timescale 1ns / 1ps
`default_nettype none
package sec_pkg;

  localparam int DET_W   = 4;
  localparam int STRIP_W = 6;
  localparam int ADC_W   = 13;
  localparam int K_W     = 3;
  localparam int COEF_W  = 40;
  localparam int E_W     = 16;
  localparam int THR_W   = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Horner accumulators stay below 7 * 2^39 in magnitude.
  localparam int ACC_W = COEF_W + 3;
  localparam int RND_W = ACC_W + 1;

  localparam int RES_TERMS  = 3;
  localparam int E_FRAC_W   = 15;  // energy read as unsigned Q1.15 for the resolution polynomial

  localparam logic [THR_W-1:0] DEFAULT_THR   = 16'd240;
  localparam logic [THR_W-1:0] FIXED_THR_RST = 16'd240;

  localparam logic [1:0] TMODE_NONE  = 2'd0;
  localparam logic [1:0] TMODE_FIXED = 2'd1;
  localparam logic [1:0] TMODE_STRIP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_THR_MODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_THR = 8'd1;

  typedef enum logic [1:0] {
    FUNC_HIT    = 2'd0,
    FUNC_LOAD_E = 2'd1,
    FUNC_LOAD_R = 2'd2,
    FUNC_LOAD_T = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_KEPT  = 2'd0,
    ST_CUT   = 2'd1,
    ST_NOCAL = 2'd2,
    ST_LOAD  = 2'd3
  } status_e;

  // Per-item side data through the energy Horner stages.
  typedef struct packed {
    func_e                             func;
    logic                              in_range;
    logic                              evalid;
    logic                              rvalid;
    logic [THR_W-1:0]                  thr;
    logic [RES_TERMS-1:0][COEF_W-1:0]  rcoef;
  } meta_t;

  // Per-item data after the threshold cut.
  typedef struct packed {
    status_e                           status;
    logic [E_W-1:0]                    energy;
    logic                              defaulted;
    logic                              rvalid;
    logic [RES_TERMS-1:0][COEF_W-1:0]  rcoef;
  } cut_t;

endpackage
`default_nettype wire

### src/sec_if.sv
// Handshake channels: hit/load input, result output and register write port.
`timescale 1ns / 1ps
`default_nettype none
interface sec_in_if;
  import sec_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic [DET_W-1:0]         detector;
  logic [STRIP_W-1:0]       strip;
  logic                     low_side;
  logic [ADC_W-1:0]         adc;
  logic [K_W-1:0]           coef_index;
  logic signed [COEF_W-1:0] load_value;
  modport source (output valid, func, detector, strip, low_side, adc, coef_index,
                  load_value, input ready);
  modport sink (input valid, func, detector, strip, low_side, adc, coef_index,
                load_value, output ready);
endinterface

interface sec_out_if;
  import sec_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [E_W-1:0]        energy;
  logic signed [E_W-1:0] resolution;
  logic                  resolution_present;
  logic                  threshold_defaulted;
  modport source (output valid, status, energy, resolution, resolution_present,
                  threshold_defaulted, input ready);
  modport sink (input valid, status, energy, resolution, resolution_present,
                threshold_defaulted, output ready);
endinterface

interface sec_cfg_if;
  import sec_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/strip_energy_calibration.sv
// Top level: per-strip polynomial energy calibration pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Per-strip energy calibration. Each input word either loads a coefficient or
// threshold into the strip's tables (func 1..3, answered with status 3) or
// calibrates a hit (func 0). A hit runs a Horner evaluation of the energy
// polynomial in adc/8192, rounds to 1/16 keV, clamps, cuts against the
// selected threshold and, when kept, evaluates the three-term resolution
// polynomial. Rate: one word per cycle, fully pipelined, while the output
// is not stalled. The word passes ENERGY_TERMS + 4 register stages (table
// read at the accepting edge, ENERGY_TERMS-1 energy Horner stages, cut
// stage, two resolution Horner stages, output register). Each Horner stage
// holds one multiplier and adder. A stalled output freezes the whole pipe.
// After reset the tables are swept to zero, one strip side per cycle,
// covering all 2*DETECTORS*STRIPS cells (2048 at default sizes); input
// ready stays low during that sweep, register writes are taken as usual.
module strip_energy_calibration #(
  parameter int DETECTORS      = 16,
  parameter int STRIPS         = 64,
  parameter int ENERGY_TERMS   = 5,
  parameter int COEF_FRAC_BITS = 16
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  sec_in_if.sink    in_i,
  sec_out_if.source out_o,
  sec_cfg_if.sink   cfg_i
);
  import sec_pkg::*;

  localparam int NCELLS = DETECTORS * STRIPS * 2;
  localparam int CW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int T      = ENERGY_TERMS;
  localparam int RSH    = COEF_FRAC_BITS - 4;
  localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (COEF_FRAC_BITS - 5);

  // ---------------- configuration registers ----------------
  logic [1:0]       tmode_q;
  logic [THR_W-1:0] fixthr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmode_q  <= TMODE_NONE;
      fixthr_q <= FIXED_THR_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_THR_MODE:  tmode_q  <= cfg_i.data[1:0];
        CFG_FIXED_THR: fixthr_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------- clearing sweep after reset ----------------
  logic          clearing_q;
  logic [CW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      if (clr_cnt_q == CW'(NCELLS - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // ---------------- pipeline control ----------------
  logic out_valid_q;
  logic advance;
  logic in_fire;

  // whole pipe moves when the output register is free or being drained
  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = advance && !clearing_q;
  assign in_fire    = in_i.valid && in_i.ready;

  // ---------------- address decode and table writes ----------------
  func_e               in_func;
  logic                in_range;
  logic [CW-1:0]       strip_addr;
  logic [CW-1:0]       waddr;
  logic [THR_W-1:0]    thr_sat;

  assign in_func    = func_e'(in_i.func);
  assign in_range   = (int'(in_i.detector) < DETECTORS) && (int'(in_i.strip) < STRIPS);
  assign strip_addr = in_range ?
                      CW'((int'(in_i.detector) * STRIPS + int'(in_i.strip)) * 2 +
                          int'(in_i.low_side)) : '0;
  assign waddr      = clearing_q ? clr_cnt_q : strip_addr;

  always_comb begin
    if (in_i.load_value < 0) begin
      thr_sat = '0;
    end else if (in_i.load_value > $signed(COEF_W'(65535))) begin
      thr_sat = '1;
    end else begin
      thr_sat = in_i.load_value[THR_W-1:0];
    end
  end

  logic load_e, load_r, load_t;
  assign load_e = in_fire && in_range && (in_func == FUNC_LOAD_E);
  assign load_r = in_fire && in_range && (in_func == FUNC_LOAD_R);
  assign load_t = in_fire && in_range && (in_func == FUNC_LOAD_T);

  // stage 0: table read registers
  logic [T-1:0][COEF_W-1:0]         ec_rd_q;
  logic [RES_TERMS-1:0][COEF_W-1:0] rc_rd_q;
  logic                             ev_rd_q, rv_rd_q;
  logic [THR_W-1:0]                 thr_rd_q;
  func_e                            func0_q;
  logic                             inrange0_q;
  logic [ADC_W-1:0]                 adc0_q;
  logic                             v0_q;

  for (genvar t = 0; t < T; t++) begin : g_emem
    logic [COEF_W-1:0] mem [NCELLS];
    logic              we;
    assign we = clearing_q || (load_e && (in_i.coef_index == K_W'(t)));
    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[waddr] <= clearing_q ? '0 : in_i.load_value;
      end
      if (in_fire) begin
        ec_rd_q[t] <= mem[strip_addr];
      end
    end
  end

  for (genvar t = 0; t < RES_TERMS; t++) begin : g_rmem
    logic [COEF_W-1:0] mem [NCELLS];
    logic              we;
    assign we = clearing_q || (load_r && (in_i.coef_index == K_W'(t)));
    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[waddr] <= clearing_q ? '0 : in_i.load_value;
      end
      if (in_fire) begin
        rc_rd_q[t] <= mem[strip_addr];
      end
    end
  end

  // valid marks are set only by a load that writes an existing term
  logic             ev_mem  [NCELLS];
  logic             rv_mem  [NCELLS];
  logic [THR_W-1:0] thr_mem [NCELLS];

  always_ff @(posedge clk_i) begin
    if (clearing_q || (load_e && (int'(in_i.coef_index) < T))) begin
      ev_mem[waddr] <= !clearing_q;
    end
    if (clearing_q || (load_r && (int'(in_i.coef_index) < RES_TERMS))) begin
      rv_mem[waddr] <= !clearing_q;
    end
    if (clearing_q || load_t) begin
      thr_mem[waddr] <= clearing_q ? '0 : thr_sat;
    end
    if (in_fire) begin
      ev_rd_q  <= ev_mem[strip_addr];
      rv_rd_q  <= rv_mem[strip_addr];
      thr_rd_q <= thr_mem[strip_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func0_q    <= in_func;
      inrange0_q <= in_range;
      adc0_q     <= in_i.adc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (advance) begin
      v0_q <= in_fire;
    end
  end

  // ---------------- energy Horner stages ----------------
  logic                     v_s    [T];
  meta_t                    meta_s [T];
  logic [ADC_W-1:0]         adc_s  [T];
  logic [T-1:0][COEF_W-1:0] ec_s   [T];
  logic signed [ACC_W-1:0]  acc_s  [T];

  assign v_s[0]    = v0_q;
  assign meta_s[0] = '{func: func0_q, in_range: inrange0_q, evalid: ev_rd_q,
                       rvalid: rv_rd_q, thr: thr_rd_q, rcoef: rc_rd_q};
  assign adc_s[0]  = adc0_q;
  assign ec_s[0]   = ec_rd_q;
  assign acc_s[0]  = ACC_W'($signed(ec_rd_q[T-1]));

  for (genvar h = 0; h < T - 1; h++) begin : g_estage
    logic                     v_q;
    meta_t                    meta_q;
    logic [ADC_W-1:0]         adc_q;
    logic [T-1:0][COEF_W-1:0] ec_q;

    sec_horner #(.AW(ACC_W), .XW(ADC_W), .CW(COEF_W), .SH(ADC_W)) u_horner (
      .clk_i  (clk_i),
      .en_i   (advance),
      .acc_i  (acc_s[h]),
      .x_i    (adc_s[h]),
      .coef_i ($signed(ec_s[h][T-2-h])),
      .acc_o  (acc_s[h+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (advance) begin
        v_q <= v_s[h];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        meta_q <= meta_s[h];
        adc_q  <= adc_s[h];
        ec_q   <= ec_s[h];
      end
    end

    assign v_s[h+1]    = v_q;
    assign meta_s[h+1] = meta_q;
    assign adc_s[h+1]  = adc_q;
    assign ec_s[h+1]   = ec_q;
  end

  // ---------------- round, clamp, threshold cut ----------------
  meta_t                   m_last;
  logic signed [RND_W-1:0] e_full;
  logic [E_W-1:0]          e_clamp;
  logic [THR_W-1:0]        thr_sel;
  logic                    thr_def;
  cut_t                    cut_d;

  assign m_last = meta_s[T-1];
  assign e_full = (RND_W'(acc_s[T-1]) + HALF) >>> RSH;

  always_comb begin
    if (e_full < 0) begin
      e_clamp = '0;
    end else if (e_full > $signed(RND_W'(65535))) begin
      e_clamp = '1;
    end else begin
      e_clamp = e_full[E_W-1:0];
    end
  end

  always_comb begin
    thr_def = 1'b0;
    unique case (tmode_q)
      TMODE_FIXED: thr_sel = fixthr_q;
      TMODE_STRIP: begin
        thr_def = (m_last.thr == '0);
        thr_sel = thr_def ? DEFAULT_THR : m_last.thr;
      end
      default: thr_sel = '0;
    endcase
  end

  always_comb begin
    cut_d           = '0;
    cut_d.rcoef     = m_last.rcoef;
    if (m_last.func != FUNC_HIT) begin
      cut_d.status = ST_LOAD;
    end else if (!m_last.in_range || !m_last.evalid) begin
      cut_d.status = ST_NOCAL;
    end else begin
      cut_d.energy    = e_clamp;
      cut_d.defaulted = thr_def;
      if (e_clamp < thr_sel) begin
        cut_d.status = ST_CUT;
      end else begin
        cut_d.status = ST_KEPT;
        cut_d.rvalid = m_last.rvalid;
      end
    end
  end

  logic ves_q;
  cut_t es_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ves_q <= 1'b0;
    end else if (advance) begin
      ves_q <= v_s[T-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      es_q <= cut_d;
    end
  end

  // ---------------- resolution Horner stages ----------------
  logic signed [ACC_W-1:0] r1_acc, r2_acc;
  logic                    vr1_q, vr2_q;
  cut_t                    r1_q, r2_q;

  sec_horner #(.AW(ACC_W), .XW(E_W), .CW(COEF_W), .SH(E_FRAC_W)) u_res1 (
    .clk_i  (clk_i),
    .en_i   (advance),
    .acc_i  (ACC_W'($signed(es_q.rcoef[RES_TERMS-1]))),
    .x_i    (es_q.energy),
    .coef_i ($signed(es_q.rcoef[RES_TERMS-2])),
    .acc_o  (r1_acc)
  );

  sec_horner #(.AW(ACC_W), .XW(E_W), .CW(COEF_W), .SH(E_FRAC_W)) u_res2 (
    .clk_i  (clk_i),
    .en_i   (advance),
    .acc_i  (r1_acc),
    .x_i    (r1_q.energy),
    .coef_i ($signed(r1_q.rcoef[RES_TERMS-3])),
    .acc_o  (r2_acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr1_q <= 1'b0;
      vr2_q <= 1'b0;
    end else if (advance) begin
      vr1_q <= ves_q;
      vr2_q <= vr1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      r1_q <= es_q;
      r2_q <= r1_q;
    end
  end

  // ---------------- sigma rounding, saturation, output register ----------------
  logic signed [RND_W-1:0] r_full;
  logic signed [E_W-1:0]   r_sat;
  logic                    res_on;

  assign r_full = (RND_W'(r2_acc) + HALF) >>> RSH;
  assign res_on = (r2_q.status == ST_KEPT) && r2_q.rvalid;

  always_comb begin
    if (!res_on) begin
      r_sat = '0;
    end else if (r_full > $signed(RND_W'(32767))) begin
      r_sat = 16'sh7FFF;
    end else if (r_full < -$signed(RND_W'(32768))) begin
      r_sat = 16'sh8000;
    end else begin
      r_sat = r_full[E_W-1:0];
    end
  end

  status_e               out_status_q;
  logic [E_W-1:0]        out_energy_q;
  logic signed [E_W-1:0] out_res_q;
  logic                  out_present_q;
  logic                  out_def_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= vr2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q  <= r2_q.status;
      out_energy_q  <= r2_q.energy;
      out_res_q     <= r_sat;
      out_present_q <= res_on;
      out_def_q     <= r2_q.defaulted;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.status              = out_status_q;
  assign out_o.energy              = out_energy_q;
  assign out_o.resolution          = out_res_q;
  assign out_o.resolution_present  = out_present_q;
  assign out_o.threshold_defaulted = out_def_q;

  // ---------------- assertions ----------------
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !in_i.ready)
    else $error("input taken during table sweep");

  a_present_only_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.resolution_present) |-> (out_o.status == ST_KEPT))
    else $error("resolution flagged on a word that was not kept");

  a_load_nocal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == ST_LOAD || out_o.status == ST_NOCAL)) |->
    (out_o.energy == '0 && !out_o.threshold_defaulted && out_o.resolution == '0))
    else $error("load or uncalibrated result carries data");

endmodule
`default_nettype wire

### src/sec_horner.sv
// One registered Horner step: acc_o = floor(acc_i * x_i / 2^SH) + coef_i.
`timescale 1ns / 1ps
`default_nettype none
module sec_horner #(
  parameter int AW = 43,
  parameter int XW = 13,
  parameter int CW = 40,
  parameter int SH = 13
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [AW-1:0] acc_i,
  input  wire logic [XW-1:0]        x_i,
  input  wire logic signed [CW-1:0] coef_i,
  output      logic signed [AW-1:0] acc_o
);

  logic signed [AW+XW:0] prod;
  logic signed [AW-1:0]  scaled;
  logic signed [AW-1:0]  acc_d;
  logic signed [AW-1:0]  acc_q;

  assign prod   = acc_i * $signed({1'b0, x_i});
  // arithmetic shift floors; the true value fits in AW bits
  assign scaled = AW'(prod >>> SH);
  assign acc_d  = scaled + AW'(coef_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire
